[hw/rtl/gimli_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Gimli permutation package
// Shared types and constants for the 384-bit round pipeline.
// ----------------------------------------------------------------------------
package gimli_pkg;

    localparam int unsigned Rounds     = 24;
    localparam int unsigned Words      = 12;
    localparam int unsigned WordW      = 32;
    localparam int unsigned RotTop     = 24;
    localparam int unsigned RotMid     = 9;
    localparam int unsigned RoundW     = $clog2(Rounds + 1);
    localparam logic [WordW-1:0] RoundConst = 32'h9e37_7900;

    typedef logic [WordW-1:0]            t_word;
    typedef logic [RoundW-1:0]           t_round;
    typedef logic [Words-1:0][WordW-1:0] t_state;

    typedef struct packed {
        t_word in_word_0;
        t_word in_word_1;
        t_word in_word_2;
        t_word in_word_3;
        t_word in_word_4;
        t_word in_word_5;
        t_word in_word_6;
        t_word in_word_7;
        t_word in_word_8;
        t_word in_word_9;
        t_word in_word_10;
        t_word in_word_11;
    } t_in_item;

    typedef struct packed {
        t_word out_word_0;
        t_word out_word_1;
        t_word out_word_2;
        t_word out_word_3;
        t_word out_word_4;
        t_word out_word_5;
        t_word out_word_6;
        t_word out_word_7;
        t_word out_word_8;
        t_word out_word_9;
        t_word out_word_10;
        t_word out_word_11;
    } t_out_item;

    // Handshake pair that passes from one round cell to the next.
    typedef struct packed {
        logic valid;
        logic ready;
    } t_link;

endpackage

[hw/rtl/sponge_permutation_384bit_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Gimli 384-bit permutation unit
// Twenty-four round cells in a chain compute the full permutation of one
// 384-bit state per transaction.
// ----------------------------------------------------------------------------
// Usage:
//   The input channel (i_valid, o_ready, i_in) carries one state of twelve
//   32-bit words per transaction; the output channel (o_valid, i_ready,
//   o_out) returns the permuted state. Word order matches the field names;
//   any byte packing is done by the driver.
//   Each round cell registers one round, and the last cell doubles as the
//   output register. Throughput is one transaction per cycle while the
//   receiver does not stall, set by the chain of 24 single-round cells.
//   Each cell accepts new data when it is empty or its neighbor takes its
//   content, so bubbles collapse: while the receiver stalls, the block keeps
//   accepting transactions until all 24 cells are full, and only then drops
//   o_ready. Nothing is lost or duplicated across a stall.
//   Reset (i_rst_n low, synchronous) clears every cell's valid bit; the data
//   registers are not reset. There is no configuration and no state between
//   transactions.
// ----------------------------------------------------------------------------
module sponge_permutation_384bit_unit (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  gimli_pkg::t_in_item   i_in,
    output logic                  o_valid,
    input  logic                  i_ready,
    output gimli_pkg::t_out_item  o_out
);

    // Link k feeds cell k; link Rounds is the output channel.
    gimli_pkg::t_link  w_link  [gimli_pkg::Rounds+1];
    gimli_pkg::t_state w_state [gimli_pkg::Rounds+1];
    logic [gimli_pkg::Rounds-1:0] w_cell_valid;

    // Unpack the input struct into the row and column word array.
    assign w_state[0][0]  = i_in.in_word_0;
    assign w_state[0][1]  = i_in.in_word_1;
    assign w_state[0][2]  = i_in.in_word_2;
    assign w_state[0][3]  = i_in.in_word_3;
    assign w_state[0][4]  = i_in.in_word_4;
    assign w_state[0][5]  = i_in.in_word_5;
    assign w_state[0][6]  = i_in.in_word_6;
    assign w_state[0][7]  = i_in.in_word_7;
    assign w_state[0][8]  = i_in.in_word_8;
    assign w_state[0][9]  = i_in.in_word_9;
    assign w_state[0][10] = i_in.in_word_10;
    assign w_state[0][11] = i_in.in_word_11;

    assign w_link[0].valid = i_valid;
    assign o_ready         = w_link[0].ready;

    // Cell k performs round Rounds - k, since rounds count down to one.
    for (genvar k = 0; k < gimli_pkg::Rounds; k++) begin : g_cell
        gimli_rnd_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_round (gimli_pkg::RoundW'(gimli_pkg::Rounds - k)),
            .i_valid (w_link[k].valid),
            .o_ready (w_link[k].ready),
            .i_state (w_state[k]),
            .o_valid (w_link[k+1].valid),
            .i_ready (w_link[k+1].ready),
            .o_state (w_state[k+1])
        );
        assign w_cell_valid[k] = w_link[k+1].valid;
    end

    assign o_valid                   = w_link[gimli_pkg::Rounds].valid;
    assign w_link[gimli_pkg::Rounds].ready = i_ready;

    // The last cell's register drives the output struct directly.
    assign o_out.out_word_0  = w_state[gimli_pkg::Rounds][0];
    assign o_out.out_word_1  = w_state[gimli_pkg::Rounds][1];
    assign o_out.out_word_2  = w_state[gimli_pkg::Rounds][2];
    assign o_out.out_word_3  = w_state[gimli_pkg::Rounds][3];
    assign o_out.out_word_4  = w_state[gimli_pkg::Rounds][4];
    assign o_out.out_word_5  = w_state[gimli_pkg::Rounds][5];
    assign o_out.out_word_6  = w_state[gimli_pkg::Rounds][6];
    assign o_out.out_word_7  = w_state[gimli_pkg::Rounds][7];
    assign o_out.out_word_8  = w_state[gimli_pkg::Rounds][8];
    assign o_out.out_word_9  = w_state[gimli_pkg::Rounds][9];
    assign o_out.out_word_10 = w_state[gimli_pkg::Rounds][10];
    assign o_out.out_word_11 = w_state[gimli_pkg::Rounds][11];

    // An accepted transaction always lands in the first cell.
    a_accept_lands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready |=> w_cell_valid[0])
        else $error("accepted transaction did not enter the first cell");

    // With no transaction entering or leaving, the number held is unchanged.
    a_count_kept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_valid && o_ready) && !(o_valid && i_ready)
        |=> $countones(w_cell_valid) == $past($countones(w_cell_valid)))
        else $error("transaction count changed without a handshake");

    // Input back-pressure only when every cell is occupied and output stalls.
    a_ready_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_ready |-> (&w_cell_valid) && !i_ready)
        else $error("input stalled while the chain had room");

endmodule

[hw/rtl/gimli_sbox.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Gimli column box
// Nonlinear mixing of one column (top, middle and bottom word).
// ----------------------------------------------------------------------------
module gimli_sbox (
    input  gimli_pkg::t_word i_top,
    input  gimli_pkg::t_word i_mid,
    input  gimli_pkg::t_word i_bot,
    output gimli_pkg::t_word o_top,
    output gimli_pkg::t_word o_mid,
    output gimli_pkg::t_word o_bot
);

    gimli_pkg::t_word w_x;
    gimli_pkg::t_word w_y;
    gimli_pkg::t_word w_z;

    // Fixed rotations are pure wiring.
    assign w_x = {i_top[gimli_pkg::WordW-gimli_pkg::RotTop-1:0],
                  i_top[gimli_pkg::WordW-1:gimli_pkg::WordW-gimli_pkg::RotTop]};
    assign w_y = {i_mid[gimli_pkg::WordW-gimli_pkg::RotMid-1:0],
                  i_mid[gimli_pkg::WordW-1:gimli_pkg::WordW-gimli_pkg::RotMid]};
    assign w_z = i_bot;

    assign o_bot = w_x ^ (w_z << 1) ^ ((w_y & w_z) << 2);
    assign o_mid = w_y ^ w_x ^ ((w_x | w_z) << 1);
    assign o_top = w_z ^ w_y ^ ((w_x & w_y) << 3);

endmodule

[hw/rtl/gimli_rnd_cell.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Gimli round cell
// One registered round: four column boxes, the row swaps and the round
// constant, with a valid bit and ready passed back to the previous cell.
// ----------------------------------------------------------------------------
module gimli_rnd_cell (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  gimli_pkg::t_round   i_round,
    input  logic                i_valid,
    output logic                o_ready,
    input  gimli_pkg::t_state   i_state,
    output logic                o_valid,
    input  logic                i_ready,
    output gimli_pkg::t_state   o_state
);

    gimli_pkg::t_state w_mixed;
    gimli_pkg::t_state n_state;
    gimli_pkg::t_state r_state;
    logic              r_valid;

    for (genvar c = 0; c < 4; c++) begin : g_col
        gimli_sbox u_sbox (
            .i_top (i_state[c]),
            .i_mid (i_state[4 + c]),
            .i_bot (i_state[8 + c]),
            .o_top (w_mixed[c]),
            .o_mid (w_mixed[4 + c]),
            .o_bot (w_mixed[8 + c])
        );
    end

    // Rounds divisible by four take the small swap plus the constant; rounds
    // two above a multiple of four take the big swap.
    always_comb begin
        n_state = w_mixed;
        unique case (i_round[1:0])
            2'd0: begin
                n_state[0] = w_mixed[1] ^ gimli_pkg::RoundConst
                             ^ gimli_pkg::WordW'(i_round);
                n_state[1] = w_mixed[0];
                n_state[2] = w_mixed[3];
                n_state[3] = w_mixed[2];
            end
            2'd2: begin
                n_state[0] = w_mixed[2];
                n_state[1] = w_mixed[3];
                n_state[2] = w_mixed[0];
                n_state[3] = w_mixed[1];
            end
            default: begin
                n_state = w_mixed;
            end
        endcase
    end

    assign o_ready = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_state <= n_state;
        end
    end

    assign o_valid = r_valid;
    assign o_state = r_state;

endmodule
